// ----- design/bounded_message_queue_assert.svh -----
// Assertion macros for the bounded message queue.
`ifndef BOUNDED_MESSAGE_QUEUE_ASSERT_SVH
`define BOUNDED_MESSAGE_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Checks a property on every clock edge outside reset.
`define BMQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition never holds.
`define BMQ_ASSERT_NEVER(lbl, cond, msg) \
	`BMQ_ASSERT(lbl, !(cond), msg)

`else

`define BMQ_ASSERT(lbl, prop, msg)
`define BMQ_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ----- design/bmq_pkg.sv -----
// Types, widths and codes shared by the bounded message queue modules.
package bmq_pkg;

	localparam int unsigned DEPTH_DEF  = 64;
	localparam int unsigned HANDLE_W   = 16;
	localparam int unsigned LEN_W      = 16;
	localparam int unsigned BYTES_W    = 24;
	localparam int unsigned CNT_W      = 7;
	localparam int unsigned MSG_MAX    = 127;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [BYTES_W-1:0] BYTE_LIMIT_RST    = 24'd4096;
	localparam logic [CNT_W-1:0]   MESSAGE_LIMIT_RST = 7'd64;

	typedef enum logic {
		OP_SEND = 1'b0,
		OP_RECV = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_REFUSED = 2'd1,
		ST_EMPTY   = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BYTE_LIMIT    = 1'b0,
		REG_MESSAGE_LIMIT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [LEN_W-1:0]    length;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] handle;
		logic [LEN_W-1:0]    length;
		logic [CNT_W-1:0]    messages;
		logic [BYTES_W-1:0]  bytes;
	} result_t;

endpackage

// ----- design/bmq_store.sv -----
// Descriptor store: one write port, one registered read port.
module bmq_store
	import bmq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF,
	parameter int unsigned IDX_W = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  entry_t           wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output entry_t           rdata
);

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/bmq_ctrl.sv -----
// Queue control: limits, pointers, counts and the result stage.
module bmq_ctrl
	import bmq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF,
	parameter int unsigned IDX_W = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_reg_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  opcode_t               in_op,
	input  entry_t                in_entry,
	output logic                  mem_we,
	output logic [IDX_W-1:0]      mem_waddr,
	output entry_t                mem_wdata,
	output logic                  mem_re,
	output logic [IDX_W-1:0]      mem_raddr,
	input  entry_t                mem_rdata,
	output logic                  res_valid,
	input  logic                  res_ready,
	output result_t               res
);

	localparam int unsigned DEPTH_CAP = (DEPTH > MSG_MAX) ? MSG_MAX : DEPTH;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	logic [BYTES_W-1:0] byte_limit_q;
	logic [CNT_W-1:0]   message_limit_q;
	logic [IDX_W-1:0]   oldest_q;
	logic [IDX_W-1:0]   newest_q;
	logic [CNT_W-1:0]   count_q;
	logic [BYTES_W-1:0] byte_count_q;

	logic               s1_valid_q;
	logic               s1_rx_q;
	status_t            s1_status_q;
	logic [CNT_W-1:0]   s1_msgs_q;
	logic [BYTES_W-1:0] s1_bytes_q;

	logic               accept;
	logic               is_send;
	logic [BYTES_W:0]   sum;
	logic               byte_over;
	logic [CNT_W-1:0]   cap;
	logic               cnt_full;
	logic               send_ok;
	logic               s1_fire;
	logic [BYTES_W-1:0] rx_len;
	logic [BYTES_W-1:0] bytes_sub;

	// A dequeue holds the input back until its length is back from the store.
	assign in_ready  = !s1_valid_q || (res_ready && !s1_rx_q);
	assign accept    = in_valid && in_ready;
	assign is_send   = (in_op == OP_SEND);

	assign sum       = {1'b0, byte_count_q} + (BYTES_W+1)'(in_entry.length);
	assign byte_over = sum > {1'b0, byte_limit_q};
	assign cap       = (message_limit_q < CNT_W'(DEPTH_CAP)) ? message_limit_q
	                                                         : CNT_W'(DEPTH_CAP);
	assign cnt_full  = count_q >= cap;
	assign send_ok   = !byte_over && !cnt_full;

	assign mem_we    = accept && is_send && send_ok;
	assign mem_waddr = newest_q;
	assign mem_wdata = in_entry;
	assign mem_re    = accept && !is_send && (count_q != '0);
	assign mem_raddr = oldest_q;

	assign s1_fire   = s1_valid_q && res_ready;
	assign rx_len    = BYTES_W'(mem_rdata.length);
	assign bytes_sub = (byte_count_q >= rx_len) ? (byte_count_q - rx_len) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_limit_q    <= BYTE_LIMIT_RST;
			message_limit_q <= MESSAGE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BYTE_LIMIT:    byte_limit_q    <= cfg_data[BYTES_W-1:0];
				REG_MESSAGE_LIMIT: message_limit_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q     <= '0;
			newest_q     <= '0;
			count_q      <= '0;
			byte_count_q <= '0;
		end else begin
			if (mem_we) begin
				newest_q     <= (newest_q == LAST_IDX) ? '0 : newest_q + 1'b1;
				count_q      <= count_q + 1'b1;
				byte_count_q <= sum[BYTES_W-1:0];
			end
			if (mem_re) begin
				oldest_q <= (oldest_q == LAST_IDX) ? '0 : oldest_q + 1'b1;
				count_q  <= count_q - 1'b1;
			end
			if (s1_fire && s1_rx_q) begin
				byte_count_q <= bytes_sub;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s1_rx_q    <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
			s1_rx_q    <= mem_re;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
			s1_rx_q    <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_send) begin
				s1_status_q <= send_ok ? ST_DONE : ST_REFUSED;
				s1_msgs_q   <= send_ok ? count_q + 1'b1 : count_q;
				s1_bytes_q  <= send_ok ? sum[BYTES_W-1:0] : byte_count_q;
			end else begin
				s1_status_q <= (count_q != '0) ? ST_DONE : ST_EMPTY;
				s1_msgs_q   <= (count_q != '0) ? count_q - 1'b1 : count_q;
				s1_bytes_q  <= byte_count_q;
			end
		end
	end

	assign res_valid    = s1_valid_q;
	assign res.status   = s1_status_q;
	assign res.handle   = s1_rx_q ? mem_rdata.handle : '0;
	assign res.length   = s1_rx_q ? mem_rdata.length : '0;
	assign res.messages = s1_msgs_q;
	assign res.bytes    = s1_rx_q ? bytes_sub : s1_bytes_q;

`include "bounded_message_queue_assert.svh"

	`BMQ_ASSERT(a_count_cap, count_q <= CNT_W'(DEPTH_CAP), "message count above depth")
	`BMQ_ASSERT(a_deq_count, mem_re |=> count_q == $past(count_q) - 1'b1, "dequeue count slip")
	`BMQ_ASSERT(a_refuse_keeps, accept && is_send && !send_ok |=> $stable(byte_count_q) && $stable(count_q), "refused send changed state")
	`BMQ_ASSERT(a_empty_no_bytes, (count_q == '0) && !(s1_valid_q && s1_rx_q) |-> byte_count_q == '0, "bytes held with empty queue")

endmodule

// ----- design/bounded_message_queue.sv -----
// Two register stages: the result stage, then the output register that drives m_tdata.
// Sends, refusals and empty receives go back to back while results drain; a receive that
// dequeues holds new input until it leaves the result stage, waiting on its stored length.
// Reset: counts, pointers and limits are cleared or set to defaults at once (byte limit
// 4096, message limit 64); the descriptor store is not cleared and needs no sweep.
module bounded_message_queue
	import bmq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,  // message_handle[15:0], message_length[31:16]
	input  logic                  s_tuser,  // opcode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// out_handle[15:0], out_length[31:16], messages_held[38:32], bytes_held[62:39], zero
	output logic [63:0]           m_tdata,
	output logic [1:0]            m_tuser   // status
);

	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	entry_t           mem_rdata;
	entry_t           in_entry;
	logic             res_valid;
	logic             res_ready;
	result_t          res;
	logic             out_valid_q;
	result_t          out_q;

	assign in_entry.handle = s_tdata[15:0];
	assign in_entry.length = s_tdata[31:16];

	bmq_ctrl #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_reg_t'(cfg_index)),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (opcode_t'(s_tuser)),
		.in_entry  (in_entry),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	bmq_store #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register parts the result stage from the consumer
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.bytes, out_q.messages, out_q.length, out_q.handle};
	assign m_tuser  = out_q.status;

endmodule
